>>> src/tsce_pkg.sv
// Shared constants and types for the touch sample calibration block.
`timescale 1ns / 1ps
`default_nettype none

package tsce_pkg;

   localparam int SAMPLE_BITS   = 12;
   localparam int SCREEN_WIDTH  = 320;
   localparam int SCREEN_HEIGHT = 240;
   localparam int CAL_OFFSET    = 20;
   localparam int FRAC_BITS     = 16;

   // dividends of the scale recompute, (size - 1 - 2*offset) in 9.16
   localparam int NUM_X   = (SCREEN_WIDTH - 1 - 2 * CAL_OFFSET) * (1 << FRAC_BITS);
   localparam int NUM_Y   = (SCREEN_HEIGHT - 1 - 2 * CAL_OFFSET) * (1 << FRAC_BITS);
   localparam int NUM_MAX = (NUM_X > NUM_Y) ? NUM_X : NUM_Y;
   localparam int DIV_W   = $clog2(NUM_MAX + 1);
   localparam int SCALE_W = (DIV_W > FRAC_BITS + 1) ? DIV_W : FRAC_BITS + 1;
   localparam int MAG_W   = SCALE_W + SAMPLE_BITS;
   localparam int PROD_W  = MAG_W + 1;
   localparam int QI_W    = MAG_W - FRAC_BITS;
   localparam int CNT_W   = $clog2((DIV_W > SAMPLE_BITS) ? DIV_W : SAMPLE_BITS);

   localparam int PIX_X_W   = $clog2(SCREEN_WIDTH);
   localparam int PIX_Y_W   = $clog2(SCREEN_HEIGHT);
   localparam int PIX_MAX_W = (PIX_X_W > PIX_Y_W) ? PIX_X_W : PIX_Y_W;

   localparam int EVENT_W    = 2;
   localparam int REQ_FIELDS = 4 * SAMPLE_BITS;
   localparam int REQ_W      = ((REQ_FIELDS + 7) / 8) * 8;
   localparam int RSP_FIELDS = EVENT_W + PIX_X_W + PIX_Y_W;
   localparam int RSP_W      = ((RSP_FIELDS + 7) / 8) * 8;
   localparam int RSP_PAD    = RSP_W - RSP_FIELDS;

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_X_LOW   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_Y_LOW   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_X_HIGH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_Y_HIGH  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FLIP_SCREEN = 3'd5;

   localparam logic [SAMPLE_BITS-1:0] THRESHOLD_RESET = SAMPLE_BITS'(2000);

   typedef enum logic [EVENT_W-1:0] {
      EV_NONE     = 2'd0,
      EV_PRESSED  = 2'd1,
      EV_RELEASED = 2'd2,
      EV_DOWN     = 2'd3
   } event_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_DIV  = 4'b0010,
      ST_MUL  = 4'b0100,
      ST_OUT  = 4'b1000
   } state_type;

endpackage

`default_nettype wire

>>> src/touch_sample_calibrate_and_events.sv
// Resistive touch press detection, event generation and two-point calibration.
`timescale 1ns / 1ps
`default_nettype none

// Each accepted item is one sample set; it yields exactly one result item with
// the touch event and the held raw position mapped to pixels. After acceptance
// the item passes through the multiply state and then the output state, which
// loads the result once the output register is free or being read. The multiply
// state is a bit-serial shift-add multiplier that applies the 9.16 scale, one
// multiplier bit per cycle for both axes side by side. After any write to a
// calibration register the input is held off while two restoring dividers, one
// quotient bit per cycle, recompute the scales. The next item is taken as soon
// as the last result has been loaded into the output register, even if it is
// not yet read.
module touch_sample_calibrate_and_events (
   input  wire                          clock,
   input  wire                          reset,
   // sense_first, raw_y, raw_x, sense_second (from bit 0 up)
   input  wire                          req_tvalid,
   output logic                         req_tready,
   input  wire  [tsce_pkg::REQ_W-1:0]   req_tdata,
   // touch_event, pixel_x, pixel_y, zero pad (from bit 0 up)
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   output logic [tsce_pkg::RSP_W-1:0]   rsp_tdata,
   input  wire                          csr_we,
   input  wire  [tsce_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire  [tsce_pkg::SAMPLE_BITS-1:0] csr_wdata
);
   import tsce_pkg::*;

   localparam int SB = SAMPLE_BITS;

   // one restoring division step: returns {new remainder, quotient bit}
   function automatic logic [SB:0] div_step(input logic [SB-1:0] rem,
                                            input logic          nbit,
                                            input logic [SB-1:0] dvs);
      logic [SB:0] t;
      logic [SB:0] d;
      t = {rem, nbit};
      d = t - {1'b0, dvs};
      if (t >= {1'b0, dvs}) begin
         div_step = {d[SB-1:0], 1'b1};
      end else begin
         div_step = {t[SB-1:0], 1'b0};
      end
   endfunction

   // one shift-add multiply step, multiplier held in the low bits
   function automatic logic [PROD_W-1:0] mul_step(input logic [PROD_W-1:0]  p,
                                                  input logic [SCALE_W-1:0] sc);
      logic [SCALE_W:0] sum;
      sum = p[PROD_W-1:SB] + (p[0] ? {1'b0, sc} : '0);
      mul_step = {1'b0, sum, p[SB-1:1]};
   endfunction

   // floor shift, offset, clamp and optional mirror of one axis
   function automatic logic [PIX_MAX_W-1:0] map_pixel(input logic [MAG_W-1:0]     mag,
                                                      input logic                 neg,
                                                      input logic                 flip,
                                                      input logic [PIX_MAX_W-1:0] last);
      logic [QI_W:0]        qn;
      logic [PIX_MAX_W-1:0] v;
      qn = {1'b0, mag[MAG_W-1:FRAC_BITS]};
      if (neg) begin
         // floor of a negative value rounds away from zero
         qn = qn + (QI_W+1)'(|mag[FRAC_BITS-1:0]);
         if (qn > (QI_W+1)'(CAL_OFFSET)) begin
            v = '0;
         end else begin
            v = PIX_MAX_W'(CAL_OFFSET) - qn[PIX_MAX_W-1:0];
         end
      end else begin
         if (qn >= (QI_W+1)'(last) - (QI_W+1)'(CAL_OFFSET)) begin
            v = last;
         end else begin
            v = qn[PIX_MAX_W-1:0] + PIX_MAX_W'(CAL_OFFSET);
         end
      end
      if (flip) begin
         v = last - v;
      end
      map_pixel = v;
   endfunction

   localparam logic [PIX_MAX_W-1:0] LAST_X = PIX_MAX_W'(SCREEN_WIDTH - 1);
   localparam logic [PIX_MAX_W-1:0] LAST_Y = PIX_MAX_W'(SCREEN_HEIGHT - 1);
   localparam logic [SCALE_W-1:0]   UNITY  = SCALE_W'(1 << FRAC_BITS);

   // control and configuration state
   state_type         state_ff,      state_in;
   logic [CNT_W-1:0]  cnt_ff,        cnt_in;
   logic              cal_dirty_ff,  cal_dirty_in;
   logic [SB-1:0]     cal_x_low_ff,  cal_x_low_in;
   logic [SB-1:0]     cal_y_low_ff,  cal_y_low_in;
   logic [SB-1:0]     cal_x_high_ff, cal_x_high_in;
   logic [SB-1:0]     cal_y_high_ff, cal_y_high_in;
   logic [SB-1:0]     thresh_ff,     thresh_in;
   logic              flip_ff,       flip_in;
   logic              was_pressed_ff, was_pressed_in;
   logic [SB-1:0]     held_x_ff,     held_x_in;
   logic [SB-1:0]     held_y_ff,     held_y_in;
   logic [SCALE_W-1:0] scale_x_ff,   scale_x_in;
   logic [SCALE_W-1:0] scale_y_ff,   scale_y_in;
   logic              sneg_x_ff,     sneg_x_in;
   logic              sneg_y_ff,     sneg_y_in;
   logic              rsp_valid_ff,  rsp_valid_in;

   // datapath
   logic [DIV_W-1:0]  dq_x_ff,   dq_x_in;
   logic [DIV_W-1:0]  dq_y_ff,   dq_y_in;
   logic [SB-1:0]     rem_x_ff,  rem_x_in;
   logic [SB-1:0]     rem_y_ff,  rem_y_in;
   logic [SB-1:0]     dvs_x_ff,  dvs_x_in;
   logic [SB-1:0]     dvs_y_ff,  dvs_y_in;
   logic              dneg_x_ff, dneg_x_in;
   logic              dneg_y_ff, dneg_y_in;
   logic              dzero_ff,  dzero_in;
   logic [PROD_W-1:0] prod_x_ff, prod_x_in;
   logic [PROD_W-1:0] prod_y_ff, prod_y_in;
   logic              pneg_x_ff, pneg_x_in;
   logic              pneg_y_ff, pneg_y_in;
   event_type         event_ff,  event_in;
   event_type         rsp_event_ff, rsp_event_in;
   logic [PIX_X_W-1:0] rsp_px_ff, rsp_px_in;
   logic [PIX_Y_W-1:0] rsp_py_ff, rsp_py_in;

   logic [SB-1:0]     sense_first, raw_y, raw_x, sense_second;
   logic              req_accept, pressed, confirmed;
   logic [SB:0]       dx, dy, dd_x, dd_y;
   logic [SB:0]       step_x, step_y;
   logic [PIX_MAX_W-1:0] pix_x, pix_y;

   assign sense_first  = req_tdata[SB-1:0];
   assign raw_y        = req_tdata[2*SB-1:SB];
   assign raw_x        = req_tdata[3*SB-1:2*SB];
   assign sense_second = req_tdata[4*SB-1:3*SB];

   assign req_tready = (state_ff == ST_IDLE) && !cal_dirty_ff;
   assign req_accept = req_tvalid && req_tready;
   assign pressed    = sense_first > thresh_ff;
   assign confirmed  = pressed && (sense_second > thresh_ff);

   assign dx = {1'b0, cal_x_high_ff} - {1'b0, cal_x_low_ff};
   assign dy = {1'b0, cal_y_high_ff} - {1'b0, cal_y_low_ff};
   // offset of the position held after this item
   assign dd_x = {1'b0, confirmed ? raw_x : held_x_ff} - {1'b0, cal_x_low_ff};
   assign dd_y = {1'b0, confirmed ? raw_y : held_y_ff} - {1'b0, cal_y_low_ff};

   assign step_x = div_step(rem_x_ff, dq_x_ff[DIV_W-1], dvs_x_ff);
   assign step_y = div_step(rem_y_ff, dq_y_ff[DIV_W-1], dvs_y_ff);

   assign pix_x = map_pixel(prod_x_ff[MAG_W-1:0], pneg_x_ff, flip_ff, LAST_X);
   assign pix_y = map_pixel(prod_y_ff[MAG_W-1:0], pneg_y_ff, flip_ff, LAST_Y);

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      cal_dirty_in   = cal_dirty_ff;
      cal_x_low_in   = cal_x_low_ff;
      cal_y_low_in   = cal_y_low_ff;
      cal_x_high_in  = cal_x_high_ff;
      cal_y_high_in  = cal_y_high_ff;
      thresh_in      = thresh_ff;
      flip_in        = flip_ff;
      was_pressed_in = was_pressed_ff;
      held_x_in      = held_x_ff;
      held_y_in      = held_y_ff;
      scale_x_in     = scale_x_ff;
      scale_y_in     = scale_y_ff;
      sneg_x_in      = sneg_x_ff;
      sneg_y_in      = sneg_y_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      dq_x_in        = dq_x_ff;
      dq_y_in        = dq_y_ff;
      rem_x_in       = rem_x_ff;
      rem_y_in       = rem_y_ff;
      dvs_x_in       = dvs_x_ff;
      dvs_y_in       = dvs_y_ff;
      dneg_x_in      = dneg_x_ff;
      dneg_y_in      = dneg_y_ff;
      dzero_in       = dzero_ff;
      prod_x_in      = prod_x_ff;
      prod_y_in      = prod_y_ff;
      pneg_x_in      = pneg_x_ff;
      pneg_y_in      = pneg_y_ff;
      event_in       = event_ff;
      rsp_event_in   = rsp_event_ff;
      rsp_px_in      = rsp_px_ff;
      rsp_py_in      = rsp_py_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_CAL_X_LOW: begin
               cal_x_low_in = csr_wdata;
               cal_dirty_in = 1'b1;
            end
            CSR_CAL_Y_LOW: begin
               cal_y_low_in = csr_wdata;
               cal_dirty_in = 1'b1;
            end
            CSR_CAL_X_HIGH: begin
               cal_x_high_in = csr_wdata;
               cal_dirty_in  = 1'b1;
            end
            CSR_CAL_Y_HIGH: begin
               cal_y_high_in = csr_wdata;
               cal_dirty_in  = 1'b1;
            end
            CSR_THRESHOLD:   thresh_in = csr_wdata;
            CSR_FLIP_SCREEN: flip_in   = csr_wdata[0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (cal_dirty_ff) begin
               // a write landing during the divide sets the flag again
               cal_dirty_in = csr_we && (csr_index == CSR_CAL_X_LOW ||
                                         csr_index == CSR_CAL_Y_LOW ||
                                         csr_index == CSR_CAL_X_HIGH ||
                                         csr_index == CSR_CAL_Y_HIGH);
               dq_x_in   = DIV_W'(NUM_X);
               dq_y_in   = DIV_W'(NUM_Y);
               rem_x_in  = '0;
               rem_y_in  = '0;
               dneg_x_in = dx[SB];
               dneg_y_in = dy[SB];
               dvs_x_in  = dx[SB] ? SB'(-dx) : dx[SB-1:0];
               dvs_y_in  = dy[SB] ? SB'(-dy) : dy[SB-1:0];
               dzero_in  = (dx == '0) || (dy == '0);
               cnt_in    = CNT_W'(DIV_W - 1);
               state_in  = ST_DIV;
            end else if (req_accept) begin
               if (confirmed) begin
                  held_x_in = raw_x;
                  held_y_in = raw_y;
               end
               if (pressed != was_pressed_ff) begin
                  event_in = pressed ? EV_PRESSED : EV_RELEASED;
               end else begin
                  event_in = pressed ? EV_DOWN : EV_NONE;
               end
               was_pressed_in = pressed;
               prod_x_in = {(SCALE_W+1)'(0), dd_x[SB] ? SB'(-dd_x) : dd_x[SB-1:0]};
               prod_y_in = {(SCALE_W+1)'(0), dd_y[SB] ? SB'(-dd_y) : dd_y[SB-1:0]};
               pneg_x_in = dd_x[SB] ^ sneg_x_ff;
               pneg_y_in = dd_y[SB] ^ sneg_y_ff;
               cnt_in    = CNT_W'(SB - 1);
               state_in  = ST_MUL;
            end
         end
         ST_DIV: begin
            rem_x_in = step_x[SB:1];
            rem_y_in = step_y[SB:1];
            dq_x_in  = {dq_x_ff[DIV_W-2:0], step_x[0]};
            dq_y_in  = {dq_y_ff[DIV_W-2:0], step_y[0]};
            if (cnt_ff == '0) begin
               if (dzero_ff) begin
                  scale_x_in = UNITY;
                  scale_y_in = UNITY;
                  sneg_x_in  = 1'b0;
                  sneg_y_in  = 1'b0;
               end else begin
                  scale_x_in = SCALE_W'(dq_x_in);
                  scale_y_in = SCALE_W'(dq_y_in);
                  sneg_x_in  = dneg_x_ff;
                  sneg_y_in  = dneg_y_ff;
               end
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_MUL: begin
            prod_x_in = mul_step(prod_x_ff, scale_x_ff);
            prod_y_in = mul_step(prod_y_ff, scale_y_ff);
            if (cnt_ff == '0) begin
               state_in = ST_OUT;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_event_in = event_ff;
               rsp_px_in    = pix_x[PIX_X_W-1:0];
               rsp_py_in    = pix_y[PIX_Y_W-1:0];
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         cnt_ff         <= '0;
         cal_dirty_ff   <= 1'b0;
         cal_x_low_ff   <= '0;
         cal_y_low_ff   <= '0;
         cal_x_high_ff  <= '0;
         cal_y_high_ff  <= '0;
         thresh_ff      <= THRESHOLD_RESET;
         flip_ff        <= 1'b0;
         was_pressed_ff <= 1'b0;
         held_x_ff      <= '0;
         held_y_ff      <= '0;
         scale_x_ff     <= UNITY;
         scale_y_ff     <= UNITY;
         sneg_x_ff      <= 1'b0;
         sneg_y_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cnt_ff         <= cnt_in;
         cal_dirty_ff   <= cal_dirty_in;
         cal_x_low_ff   <= cal_x_low_in;
         cal_y_low_ff   <= cal_y_low_in;
         cal_x_high_ff  <= cal_x_high_in;
         cal_y_high_ff  <= cal_y_high_in;
         thresh_ff      <= thresh_in;
         flip_ff        <= flip_in;
         was_pressed_ff <= was_pressed_in;
         held_x_ff      <= held_x_in;
         held_y_ff      <= held_y_in;
         scale_x_ff     <= scale_x_in;
         scale_y_ff     <= scale_y_in;
         sneg_x_ff      <= sneg_x_in;
         sneg_y_ff      <= sneg_y_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dq_x_ff      <= dq_x_in;
      dq_y_ff      <= dq_y_in;
      rem_x_ff     <= rem_x_in;
      rem_y_ff     <= rem_y_in;
      dvs_x_ff     <= dvs_x_in;
      dvs_y_ff     <= dvs_y_in;
      dneg_x_ff    <= dneg_x_in;
      dneg_y_ff    <= dneg_y_in;
      dzero_ff     <= dzero_in;
      prod_x_ff    <= prod_x_in;
      prod_y_ff    <= prod_y_in;
      pneg_x_ff    <= pneg_x_in;
      pneg_y_ff    <= pneg_y_in;
      event_ff     <= event_in;
      rsp_event_ff <= rsp_event_in;
      rsp_px_ff    <= rsp_px_in;
      rsp_py_ff    <= rsp_py_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {RSP_PAD'(0), rsp_py_ff, rsp_px_ff, rsp_event_ff};

endmodule

`default_nettype wire

>>> src/tsce_checker.sv
// Port-level checks for the touch calibration block, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

module tsce_checker (
   input wire                            clock,
   input wire                            reset,
   input wire                            req_tvalid,
   input wire                            req_tready,
   input wire                            rsp_tvalid,
   input wire                            rsp_tready,
   input wire [tsce_pkg::RSP_W-1:0]      rsp_tdata,
   input wire                            csr_we,
   input wire [tsce_pkg::CSR_IDX_W-1:0]  csr_index
);
   import tsce_pkg::*;

   logic [EVENT_W-1:0] ev;
   logic               last_down_ff, last_down_in;

   assign ev = rsp_tdata[EVENT_W-1:0];
   assign last_down_in = (rsp_tvalid && rsp_tready) ?
                         (ev == EV_PRESSED || ev == EV_DOWN) : last_down_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_down_ff <= 1'b0;
      end else begin
         last_down_ff <= last_down_in;
      end
   end

   // no result straight out of reset
   a_quiet_after_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // one item in work at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item accepted while another is in work");

   // a calibration write takes input ready away so the scales can be recomputed
   a_cal_stall: assert property (@(posedge clock) disable iff (reset)
      csr_we && (csr_index == CSR_CAL_X_LOW || csr_index == CSR_CAL_Y_LOW ||
                 csr_index == CSR_CAL_X_HIGH || csr_index == CSR_CAL_Y_HIGH)
      |=> !req_tready)
      else $error("input ready straight after a calibration write");

   // events follow the press state carried by the previous result
   a_event_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (last_down_ff ? (ev == EV_RELEASED || ev == EV_DOWN)
                                   : (ev == EV_NONE || ev == EV_PRESSED)))
      else $error("event inconsistent with previous press state");

endmodule

bind touch_sample_calibrate_and_events tsce_checker u_tsce_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_we     (csr_we),
   .csr_index  (csr_index)
);

`default_nettype wire
